// File: rtl/core/tcm_pkg.sv
package tcm_pkg;

    // Default widths handed to the top level
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int HALF_W    = 16;   // one half of a packed xy register
    localparam int UV_W      = 21;   // signed Q4.16 window values
    localparam int UV_FRAC   = 16;   // fraction bits of the UV window
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int MIRROR_W  = 2;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN   = 3'd0,
        REG_EXTENT   = 3'd1,
        REG_TEX_SIZE = 3'd2,
        REG_OFFS_U   = 3'd3,
        REG_OFFS_V   = 3'd4,
        REG_SCALE_U  = 3'd5,
        REG_SCALE_V  = 3'd6,
        REG_MIRROR   = 3'd7
    } t_cfg_reg;

    // Per-axis settings taken from the register file
    typedef struct packed {
        logic [HALF_W-1:0] origin;   // signed
        logic [HALF_W-1:0] extent;   // zero means one
        logic [HALF_W-1:0] size;     // zero means one, saturated to 2^coord
        logic [UV_W-1:0]   offset;   // signed Q4.16
        logic [UV_W-1:0]   scale;    // signed Q4.16
        logic              mirror;
    } t_axis_cfg;

    // Magnitude width of pixel minus origin
    function automatic int mag_bits(input int coord);
        return ((coord > HALF_W) ? coord : HALF_W) + 1;
    endfunction

    // Register stages in one axis: entry, one per quotient bit, then five
    function automatic int pipe_depth(input int coord, input int frac);
        return mag_bits(coord) + frac + 6;
    endfunction

endpackage

// File: rtl/core/tcm_axis.sv
module tcm_axis #(
    parameter int COORD_BITS = tcm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tcm_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [COORD_BITS-1:0] i_pix,
    input  tcm_pkg::t_axis_cfg    i_cfg,
    output logic [COORD_BITS-1:0] o_texel
);

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int HW  = tcm_pkg::HALF_W;
    localparam int UW  = tcm_pkg::UV_W;
    localparam int UF  = tcm_pkg::UV_FRAC;
    localparam int M   = tcm_pkg::mag_bits(COORD_BITS);
    localparam int QB  = M + F;            // quotient bits
    localparam int SB  = QB + 1;           // signed fraction
    localparam int LO  = SB / 2;           // low partial product slice
    localparam int HI  = SB - LO;
    localparam int PB  = SB + UW;          // full product
    localparam int ZB  = C + 1;            // texture size

    // Effective extent and size
    logic [HW-1:0] ext_eff;
    logic [ZB-1:0] size_eff;
    logic [ZB-1:0] size_m1;

    always_comb begin
        ext_eff = (i_cfg.extent == '0) ? HW'(1) : i_cfg.extent;
        if (i_cfg.size == '0) begin
            size_eff = ZB'(1);
        end else if ({1'b0, i_cfg.size} > ((HW+1)'(1) << C)) begin
            size_eff = ZB'(1) << C;
        end else begin
            size_eff = ZB'(i_cfg.size);
        end
        size_m1 = size_eff - ZB'(1);
    end

    // Entry stage: offset from origin as sign and magnitude
    logic signed [M:0] d_pix, d_org, d_dif;
    logic        [M:0] d_abs;

    always_comb begin
        d_pix = $signed({{(M+1-C){1'b0}}, i_pix});
        d_org = $signed({{(M+1-HW){i_cfg.origin[HW-1]}}, i_cfg.origin});
        d_dif = d_pix - d_org;
        d_abs = d_dif[M] ? (-d_dif) : d_dif;
    end

    // Restoring divider, one quotient bit per stage
    logic [QB-1:0] r_dv_nq  [0:QB];
    logic [HW-1:0] r_dv_rem [0:QB];
    logic          r_dv_neg [0:QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_nq[0]  <= {d_abs[M-1:0], {F{1'b0}}};
            r_dv_rem[0] <= '0;
            r_dv_neg[0] <= d_dif[M];
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [HW:0] trial;
        logic [HW:0] diff;
        logic        ge;

        always_comb begin
            trial = {r_dv_rem[k], r_dv_nq[k][QB-1]};
            diff  = trial - {1'b0, ext_eff};
            ge    = (trial >= {1'b0, ext_eff});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_nq[k+1]  <= {r_dv_nq[k][QB-2:0], ge};
                r_dv_rem[k+1] <= ge ? diff[HW-1:0] : trial[HW-1:0];
                r_dv_neg[k+1] <= r_dv_neg[k];
            end
        end
    end

    // Floor of the signed quotient
    logic        [SB-1:0] q_up;
    logic signed [SB-1:0] n_s;
    logic signed [SB-1:0] r_s;

    always_comb begin
        q_up = {1'b0, r_dv_nq[QB]} + SB'(|r_dv_rem[QB]);
        n_s  = r_dv_neg[QB] ? $signed(-q_up) : $signed({1'b0, r_dv_nq[QB]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    // Fraction times scale, split into two partial products
    logic signed [LO:0]    s_lo;
    logic signed [HI-1:0]  s_hi;
    logic signed [UW-1:0]  scale_s;
    logic signed [LO+UW:0] r_plo;
    logic signed [HI+UW-1:0] r_phi;

    always_comb begin
        s_lo    = $signed({1'b0, r_s[LO-1:0]});
        s_hi    = r_s[SB-1:LO];
        scale_s = $signed(i_cfg.scale);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= s_lo * scale_s;
            r_phi <= s_hi * scale_s;
        end
    end

    // Sum the partial products
    logic signed [PB-1:0] plo_ext, phi_ext;
    logic signed [PB-1:0] r_prod;

    always_comb begin
        plo_ext = r_plo;
        phi_ext = r_phi;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (phi_ext <<< LO) + plo_ext;
        end
    end

    // Shift down, add offset, clamp to 0..1
    logic signed [PB-1:0] u_sh, u_off, u_sum;
    logic        [UF:0]   n_u;
    logic        [UF:0]   r_u;

    always_comb begin
        u_sh  = r_prod >>> F;
        u_off = $signed(i_cfg.offset);
        u_sum = u_sh + u_off;
        if (u_sum[PB-1]) begin
            n_u = '0;
        end else if ((|u_sum[PB-2:UF+1]) || (u_sum[UF] && (|u_sum[UF-1:0]))) begin
            n_u = (UF+1)'(1) << UF;
        end else begin
            n_u = u_sum[UF:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
        end
    end

    // Scale by texture size
    logic [ZB+UF:0] r_t;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= size_eff * r_u;
        end
    end

    // Floor, clamp to size-1 and mirror
    logic [ZB-1:0] t_fl, t_cl, t_mr;

    always_comb begin
        t_fl = r_t[ZB+UF-1:UF];
        t_cl = (t_fl > size_m1) ? size_m1 : t_fl;
        t_mr = i_cfg.mirror ? (size_m1 - t_cl) : t_cl;
    end

    assign o_texel = t_mr[C-1:0];

endmodule

// File: rtl/core/texture_coordinate_mapper_top.sv
// Path: an input transfer passes the entry stage, one stage per quotient bit,
//   the floor, product, sum, clamp and size registers, then the output register.
// Throughput: one pixel per cycle; a full pipeline stalls as a whole while
//   the output register and its skid stage are both occupied.
// Reset: synchronous, active low; clears valid bits and loads the register
//   defaults (unit extent and texture size, unit scale, no offset or mirror).
module texture_coordinate_mapper_top #(
    parameter int COORD_BITS = tcm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tcm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcm_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // pixel input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,  // pix_x, pix_y
    // texel output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [((4*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata   // dst_x, dst_y, texel_x, texel_y
);

    localparam int C     = COORD_BITS;
    localparam int HW    = tcm_pkg::HALF_W;
    localparam int UW    = tcm_pkg::UV_W;
    localparam int LAT   = tcm_pkg::pipe_depth(COORD_BITS, FRAC_BITS);
    localparam int OUT_W = ((4*COORD_BITS+7)/8)*8;

    // Register file
    logic [2*HW-1:0]              r_origin, r_extent, r_tex_size;
    logic [UW-1:0]                r_offs_u, r_offs_v, r_scale_u, r_scale_v;
    logic [tcm_pkg::MIRROR_W-1:0] r_mirror;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin   <= '0;
            r_extent   <= {HW'(1), HW'(1)};
            r_tex_size <= {HW'(1), HW'(1)};
            r_offs_u   <= '0;
            r_offs_v   <= '0;
            r_scale_u  <= UW'(1) << tcm_pkg::UV_FRAC;
            r_scale_v  <= UW'(1) << tcm_pkg::UV_FRAC;
            r_mirror   <= '0;
        end else if (i_cfg_valid) begin
            unique case (tcm_pkg::t_cfg_reg'(i_cfg_index))
                tcm_pkg::REG_ORIGIN:   r_origin   <= i_cfg_data;
                tcm_pkg::REG_EXTENT:   r_extent   <= i_cfg_data;
                tcm_pkg::REG_TEX_SIZE: r_tex_size <= i_cfg_data;
                tcm_pkg::REG_OFFS_U:   r_offs_u   <= i_cfg_data[UW-1:0];
                tcm_pkg::REG_OFFS_V:   r_offs_v   <= i_cfg_data[UW-1:0];
                tcm_pkg::REG_SCALE_U:  r_scale_u  <= i_cfg_data[UW-1:0];
                tcm_pkg::REG_SCALE_V:  r_scale_v  <= i_cfg_data[UW-1:0];
                tcm_pkg::REG_MIRROR:   r_mirror   <= i_cfg_data[tcm_pkg::MIRROR_W-1:0];
            endcase
        end
    end

    // Per-axis settings
    tcm_pkg::t_axis_cfg cfg_x, cfg_y;

    always_comb begin
        cfg_x.origin = r_origin[HW-1:0];
        cfg_x.extent = r_extent[HW-1:0];
        cfg_x.size   = r_tex_size[HW-1:0];
        cfg_x.offset = r_offs_u;
        cfg_x.scale  = r_scale_u;
        cfg_x.mirror = r_mirror[0];
        cfg_y.origin = r_origin[2*HW-1:HW];
        cfg_y.extent = r_extent[2*HW-1:HW];
        cfg_y.size   = r_tex_size[2*HW-1:HW];
        cfg_y.offset = r_offs_v;
        cfg_y.scale  = r_scale_v;
        cfg_y.mirror = r_mirror[1];
    end

    // Output register plus skid stage; the pipeline advances while skid is free
    logic           r_skid_valid, r_out_valid;
    logic [4*C-1:0] r_skid_data, r_out_data;
    logic           pipe_en;

    assign pipe_en         = !r_skid_valid;
    assign o_s_axis_tready = pipe_en;

    // Valid bits and the pass-through coordinate travel beside the axis pipes
    logic           r_vld [0:LAT-1];
    logic [2*C-1:0] r_dst [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (pipe_en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dst[0] <= i_s_axis_tdata[2*C-1:0];
            for (int k = 1; k < LAT; k++) begin
                r_dst[k] <= r_dst[k-1];
            end
        end
    end

    // Axis pipes
    logic [C-1:0] texel_x, texel_y;

    tcm_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_pix   (i_s_axis_tdata[C-1:0]),
        .i_cfg   (cfg_x),
        .o_texel (texel_x)
    );

    tcm_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_pix   (i_s_axis_tdata[2*C-1:C]),
        .i_cfg   (cfg_y),
        .o_texel (texel_y)
    );

    // Result leaving the pipe
    logic           push;
    logic           out_take;
    logic [4*C-1:0] push_data;

    assign push      = pipe_en && r_vld[LAT-1];
    assign out_take  = r_out_valid && i_m_axis_tready;
    assign push_data = {texel_y, texel_x, r_dst[LAT-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (push) begin
            if (!r_out_valid || out_take) begin
                r_out_data <= push_data;
            end else begin
                r_skid_data <= push_data;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    a_blocked_push_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_out_valid && !i_m_axis_tready) |=> r_skid_valid)
        else $error("result leaving the pipe was not parked in the skid stage");

    a_frozen_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_vld[LAT-1]))
        else $error("pipeline moved while stalled");

endmodule
